// File: rtl/core/tlv_section_indexer_assert.svh
// Assertion helpers shared by the section indexer modules.
`ifndef TLV_SECTION_INDEXER_ASSERT_SVH
`define TLV_SECTION_INDEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSI_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tsi: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tsi: next-cycle check failed");

`endif

// File: rtl/core/tsi_pkg.sv
`default_nettype none

package tsi_pkg;

  localparam int unsigned NumSections = 4;
  localparam int unsigned IdW         = 32;
  localparam int unsigned SecW        = $clog2(NumSections);
  localparam int unsigned HdrLanes    = 7;   // header bytes held before the last one arrives
  localparam int unsigned FifoDepth   = 2;

  localparam logic [2:0] KindReport = 3'd4;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusFormat  = 2'd1,
    StatusMissing = 2'd2
  } status_e;

  typedef logic [NumSections-1:0][IdW-1:0] id_array_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [31:0]     payload_offset;
    logic [31:0]     payload_size;
    status_e         status;
    logic [SecW-1:0] missing_section;
    logic            last;
  } result_t;

  // Results produced by one step, in delivery order.
  typedef struct packed {
    logic [1:0] n;
    result_t    a;
    result_t    b;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/tsi_parser.sv
`default_nettype none

module tsi_parser
  import tsi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  id_array_t  section_id_i,
  input  logic       step_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_file_i,
  input  logic [1:0] free_slots_i,
  output logic       consume_o,
  output push_t      push_o
);

  logic [31:0]     pos_q, pos_d;
  logic            in_payload_q, in_payload_d;
  logic [2:0]      count_q, count_d;
  logic [31:0]     rem_q, rem_d;
  logic [NumSections-1:0] found_q, found_d;
  logic [7:0]      hdr_q [HdrLanes];

  logic [31:0]     hdr_id, hdr_size;
  logic            hit;
  logic [SecW-1:0] hit_idx;
  logic            match_fire;
  logic            payload_nx;
  logic [2:0]      count_nx;
  logic [NumSections-1:0] found_nx;
  status_e         rep_status;
  logic [SecW-1:0] rep_miss;
  logic [1:0]      n_res;
  result_t         res_match, res_rep;

  assign hdr_id   = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign hdr_size = {data_byte_i, hdr_q[6], hdr_q[5], hdr_q[4]};

  // First matching register wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = 0; s < NumSections; s++) begin
      if (!hit && hdr_id == section_id_i[s]) begin
        hit     = 1'b1;
        hit_idx = SecW'(s);
      end
    end
  end

  assign match_fire = has_byte_i && !in_payload_q && (count_q == 3'd7) && hit;

  // Byte part of the step.
  always_comb begin
    payload_nx = in_payload_q;
    count_nx   = count_q;
    found_nx   = found_q;
    rem_d      = rem_q;
    if (has_byte_i) begin
      if (in_payload_q) begin
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          payload_nx = 1'b0;
        end
      end else if (count_q == 3'd7) begin
        count_nx   = '0;
        rem_d      = hdr_size;
        payload_nx = (hdr_size != 32'd0);
        if (hit) begin
          found_nx[hit_idx] = 1'b1;
        end
      end else begin
        count_nx = count_q + 3'd1;
      end
    end
  end

  // End-of-file verdict: truncation outranks missing sections.
  always_comb begin
    rep_status = StatusOk;
    rep_miss   = '0;
    if (payload_nx || count_nx != 3'd0) begin
      rep_status = StatusFormat;
    end else begin
      for (int s = NumSections - 1; s >= 0; s--) begin
        if (!found_nx[s]) begin
          rep_status = StatusMissing;
          rep_miss   = SecW'(s);
        end
      end
    end
  end

  always_comb begin
    res_match                 = '0;
    res_match.kind            = 3'(hit_idx);
    res_match.payload_offset  = pos_q + 32'd1;
    res_match.payload_size    = hdr_size;
    res_match.status          = StatusOk;
    res_rep                   = '0;
    res_rep.kind              = KindReport;
    res_rep.status            = rep_status;
    res_rep.missing_section   = rep_miss;
    res_rep.last              = 1'b1;
  end

  assign n_res     = {1'b0, match_fire} + {1'b0, end_of_file_i};
  assign consume_o = step_valid_i && (n_res <= free_slots_i);

  always_comb begin
    push_o.n = consume_o ? n_res : 2'd0;
    push_o.a = match_fire ? res_match : res_rep;
    push_o.b = res_rep;
  end

  // Commit the step; an end marker drops all stream state.
  always_comb begin
    pos_d        = pos_q;
    in_payload_d = in_payload_q;
    count_d      = count_q;
    found_d      = found_q;
    if (consume_o) begin
      if (end_of_file_i) begin
        pos_d        = '0;
        in_payload_d = 1'b0;
        count_d      = '0;
        found_d      = '0;
      end else begin
        pos_d        = has_byte_i ? pos_q + 32'd1 : pos_q;
        in_payload_d = payload_nx;
        count_d      = count_nx;
        found_d      = found_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_payload_q <= 1'b0;
      count_q      <= '0;
      rem_q        <= '0;
      found_q      <= '0;
    end else begin
      pos_q        <= pos_d;
      in_payload_q <= in_payload_d;
      count_q      <= count_d;
      found_q      <= found_d;
      if (consume_o && !end_of_file_i) begin
        rem_q <= rem_d;
      end else if (consume_o) begin
        rem_q <= '0;
      end
    end
  end

  // Header lanes are each written once per header, so they need no clear.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < HdrLanes; l++) begin
      if (consume_o && has_byte_i && !in_payload_q && count_q == 3'(l)) begin
        hdr_q[l] <= data_byte_i;
      end
    end
  end

`include "tlv_section_indexer_assert.svh"

  `TSI_ASSERT_NOW(a_two_results_order, clk_i, rst_ni, push_o.n == 2'd2, !push_o.a.last && push_o.b.last)
  `TSI_ASSERT_NEXT(a_eof_clears, clk_i, rst_ni, consume_o && end_of_file_i, pos_q == 32'd0 && !in_payload_q && count_q == 3'd0 && found_q == '0)
  `TSI_ASSERT_NOW(a_payload_phase, clk_i, rst_ni, in_payload_q, count_q == 3'd0 && rem_q != 32'd0)

endmodule

`default_nettype wire

// File: rtl/core/tsi_result_fifo.sv
`default_nettype none

module tsi_result_fifo
  import tsi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic [1:0] free_slots_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    data_o
);

  result_t    slot_q [FifoDepth];
  result_t    slot_d [FifoDepth];
  logic [1:0] count_q, count_d;
  logic [1:0] kept;
  logic       pop;
  logic [2:0] fill_sum;

  assign valid_o      = (count_q != 2'd0);
  assign data_o       = slot_q[0];
  assign free_slots_o = 2'(FifoDepth) - count_q;
  assign pop          = valid_o && ready_i;
  assign kept         = count_q - {1'b0, pop};
  assign count_d      = kept + push_i.n;
  assign fill_sum     = {1'b0, count_q} + {1'b0, push_i.n};

  // Shift the survivor to the head, then append new results.
  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    case (kept)
      2'd0: begin
        slot_d[0] = push_i.a;
        slot_d[1] = push_i.b;
      end
      2'd1: begin
        slot_d[0] = pop ? slot_q[1] : slot_q[0];
        slot_d[1] = push_i.a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

`include "tlv_section_indexer_assert.svh"

  `TSI_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, 1'b1, fill_sum <= 3'd2)
  `TSI_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= 2'd2)
  `TSI_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, count_q == 2'd2 && !pop,
                   $stable(slot_q[0]) && $stable(slot_q[1]))

endmodule

`default_nettype wire

// File: rtl/core/tlv_section_indexer.sv
`default_nettype none

// Channel  | Dir | Handshake              | Contents
// s_axis   | in  | tvalid / tready        | one file byte, byte flag, end of file
// m_axis   | out | tvalid / tready        | match result or end-of-file report
// cfg      | in  | cfg_valid / cfg_ready  | section identifier register writes
//
// One byte per cycle sustained while the result buffer has room. A result is
// offered once its byte has passed the input register and landed in the buffer.
// A byte that both closes a matching header and ends the file yields two
// results and needs the result buffer empty, so it may wait for the
// previous result to leave, and the next result-bearing byte waits behind it.
// Reset clears the stream state, the buffer count and the identifier registers.
// Input and output stall independently; the input register holds while the
// buffer lacks room for the results of the waiting transaction.

module tlv_section_indexer
  import tsi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Input stream
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,  // [7:0] data_byte
  input  logic            s_axis_tuser_i,  // [0] has_byte
  input  logic            s_axis_tlast_i,  // end_of_file
  // Result stream
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // [31:0] payload_offset, [63:32] payload_size, [65:64] status,
  // [67:66] missing_section, [71:68] zero
  output logic [71:0]     m_axis_tdata_o,
  output logic [2:0]      m_axis_tuser_o,  // [2:0] kind
  output logic            m_axis_tlast_o,  // last
  // Configuration writes
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [SecW-1:0] cfg_index_i,
  input  logic [IdW-1:0]  cfg_data_i
);

  // Identifier registers, reset to zero.
  id_array_t  section_id_q;

  // Input register holding one accepted transaction.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_has_q;
  logic       in_eof_q;

  logic       s_accept;
  logic       consume;
  logic [1:0] free_slots;
  push_t      push;
  result_t    head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_id_q <= '0;
    end else if (cfg_valid_i) begin
      section_id_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Take a new transaction whenever the register is empty or drains this cycle.
  assign s_axis_tready_o = !in_valid_q || consume;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_has_q  <= s_axis_tuser_i;
      in_eof_q  <= s_axis_tlast_i;
    end
  end

  // Header assembly, identifier match and end-of-file verdict.
  tsi_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .section_id_i  (section_id_q),
    .step_valid_i  (in_valid_q),
    .data_byte_i   (in_byte_q),
    .has_byte_i    (in_has_q),
    .end_of_file_i (in_eof_q),
    .free_slots_i  (free_slots),
    .consume_o     (consume),
    .push_o        (push)
  );

  // Result register: two entries so a match and its report can land together.
  tsi_result_fifo u_results (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .free_slots_o (free_slots),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .data_o       (head)
  );

  assign m_axis_tdata_o = {4'b0000, head.missing_section, head.status,
                           head.payload_size, head.payload_offset};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire
